[design/eefb_pkg.sv]
`default_nettype none
package eefb_pkg;

   // input kind carried on req_tuser
   localparam logic REQ_EVENT = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // configuration register indexes
   localparam logic CSR_MAGIC    = 1'b0;
   localparam logic CSR_INTERVAL = 1'b1;

   localparam int unsigned COUNT_CAP  = 15;
   localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

   localparam logic [7:0]  MAGIC_RESET    = 8'd0;
   localparam logic [15:0] INTERVAL_RESET = 16'd30;

   typedef struct packed {
      logic [7:0]  lvl;
      logic [7:0]  ch;
      logic [31:0] t;
   } edge_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

endpackage
`default_nettype wire

[design/edge_event_frame_builder_unit.sv]
// channel  dir  fields
// req_     in   tuser: req_type; tdata: event_time_us, event_channel, event_level, now_ms
// rsp_     out  tuser: is_header; tlast: last; tdata: frame_magic .. rec_level
// csr_     in   index 0 magic_byte, index 1 interval_ms
//
// an edge event is taken while the unit is idle and written to the queue memory, events can follow
// back to back
// a tick holds req_tready low while the shared 32-bit subtractor
// checks the elapsed time
// a built frame shows its header after the check (S_CHECK) and the first entry read (S_FIRST),
// the first record after the header is taken and S_CALC has run, each later record after the one
// before is taken and S_READ and S_CALC have run (head update and memory read, then subtractor
// into the output register), plus stalls; req_tready is low from a tick until the last word of
// its frame is taken, or until the elapsed-time check when no frame is built
// reset is synchronous and active high and empties the queue
`default_nettype none
module edge_event_frame_builder_unit #(
   parameter int MAX_EVENTS  = 15,
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic         req_tuser,   // req_type
   // event_time_us, event_channel, event_level, now_ms
   input  wire logic [79:0]  req_tdata,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic         rsp_tuser,   // is_header
   output      logic         rsp_tlast,   // last
   // frame_magic, frame_seq, first_time_us, event_count, time_offset,
   // rec_channel, rec_level, zero fill
   output      logic [111:0] rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [0:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);
   import eefb_pkg::*;

   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   logic [7:0]     magic_ff, magic_in;
   logic [15:0]    interval_ff, interval_in;
   logic           idle;
   logic           req_acc;
   queue_ctl_type  seq_ctl, q_ctl;
   edge_entry_type wr_entry, rd_entry;
   logic [FW-1:0]  fill;

   always_comb begin
      magic_in    = magic_ff;
      interval_in = interval_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAGIC:    magic_in    = csr_wdata[7:0];
            CSR_INTERVAL: interval_in = csr_wdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff    <= MAGIC_RESET;
         interval_ff <= INTERVAL_RESET;
      end else begin
         magic_ff    <= magic_in;
         interval_ff <= interval_in;
      end
   end

   assign req_tready = idle;
   assign req_acc    = req_tvalid && req_tready;

   assign wr_entry.t   = req_tdata[31:0];
   assign wr_entry.ch  = req_tdata[39:32];
   assign wr_entry.lvl = req_tdata[47:40];

   assign q_ctl.push = req_acc && (req_tuser == REQ_EVENT);
   assign q_ctl.pop  = seq_ctl.pop;

   eefb_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .FW          (FW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (q_ctl),
      .wr_entry (wr_entry),
      .fill     (fill),
      .rd_entry (rd_entry)
   );

   eefb_seq #(
      .MAX_EVENTS (MAX_EVENTS),
      .FW         (FW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_acc && (req_tuser == REQ_TICK)),
      .now_ms     (req_tdata[79:48]),
      .magic      (magic_ff),
      .interval   (interval_ff),
      .fill       (fill),
      .rd_entry   (rd_entry),
      .pop_ctl    (seq_ctl),
      .idle       (idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

[design/eefb_queue.sv]
`default_nettype none
module eefb_queue #(
   parameter int QUEUE_DEPTH = 64,
   parameter int FW          = 7
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire eefb_pkg::queue_ctl_type ctl,
   input  wire eefb_pkg::edge_entry_type wr_entry,
   output      logic [FW-1:0]           fill,
   output      eefb_pkg::edge_entry_type rd_entry
);
   import eefb_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   edge_entry_type mem [QUEUE_DEPTH];
   edge_entry_type rd_ff;
   logic [AW-1:0]  head_ff, head_in;
   logic [AW-1:0]  tail_ff, tail_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic           full;
   logic           do_push;

   assign full    = (fill_ff == FW'(QUEUE_DEPTH));
   // a full queue drops the new word
   assign do_push = ctl.push && !full;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (do_push) begin
         tail_in = (tail_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + AW'(1);
         fill_in = fill_ff + FW'(1);
      end
      if (ctl.pop) begin
         head_in = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= wr_entry;
      end
      rd_ff <= mem[head_ff];
   end

   assign fill     = fill_ff;
   assign rd_entry = rd_ff;

endmodule
`default_nettype wire

[design/eefb_seq.sv]
`default_nettype none
module eefb_seq #(
   parameter int MAX_EVENTS = 15,
   parameter int FW         = 7
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [31:0]              now_ms,
   input  wire logic [7:0]               magic,
   input  wire logic [15:0]              interval,
   input  wire logic [FW-1:0]            fill,
   input  wire eefb_pkg::edge_entry_type rd_entry,
   output      eefb_pkg::queue_ctl_type  pop_ctl,
   output      logic                     idle,
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic                     rsp_tuser,
   output      logic                     rsp_tlast,
   output      logic [111:0]             rsp_tdata
);
   import eefb_pkg::*;

   localparam int unsigned LIMIT = (MAX_EVENTS < COUNT_CAP) ? MAX_EVENTS : COUNT_CAP;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_FIRST = 7'b0000100,
      S_HDR   = 7'b0001000,
      S_CALC  = 7'b0010000,
      S_REC   = 7'b0100000,
      S_READ  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] last_build_ff, last_build_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] first_ff, first_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  rem_ff, rem_in;

   logic        valid_ff, valid_in;
   logic        hdr_ff, hdr_in;
   logic        last_ff, last_in;
   logic [7:0]  o_magic_ff, o_magic_in;
   logic [31:0] o_seq_ff, o_seq_in;
   logic [31:0] o_first_ff, o_first_in;
   logic [3:0]  o_cnt_ff, o_cnt_in;
   logic [15:0] o_off_ff, o_off_in;
   logic [7:0]  o_ch_ff, o_ch_in;
   logic [7:0]  o_lvl_ff, o_lvl_in;

   // shared subtractor: elapsed ms on a tick, event offset on a record
   logic [31:0] sub_a, sub_b, diff;
   logic [3:0]  take_n;
   logic        pop;

   always_comb begin
      if (state_ff == S_CHECK) begin
         sub_a = now_ff;
         sub_b = last_build_ff;
      end else begin
         sub_a = rd_entry.t;
         sub_b = first_ff;
      end
      diff = sub_a - sub_b;
   end

   assign take_n = (32'(fill) < 32'(LIMIT)) ? 4'(fill) : 4'(LIMIT);

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      last_build_in = last_build_ff;
      seq_in        = seq_ff;
      first_in      = first_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      valid_in      = valid_ff;
      hdr_in        = hdr_ff;
      last_in       = last_ff;
      o_magic_in    = o_magic_ff;
      o_seq_in      = o_seq_ff;
      o_first_in    = o_first_ff;
      o_cnt_in      = o_cnt_ff;
      o_off_in      = o_off_ff;
      o_ch_in       = o_ch_ff;
      o_lvl_in      = o_lvl_ff;
      pop           = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               now_in   = now_ms;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (diff < {16'd0, interval}) begin
               state_in = S_IDLE;
            end else begin
               last_build_in = now_ff;
               if (take_n == 4'd0) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = take_n;
                  rem_in   = take_n;
                  state_in = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            first_in   = rd_entry.t;
            valid_in   = 1'b1;
            hdr_in     = 1'b1;
            last_in    = 1'b0;
            o_magic_in = magic;
            o_seq_in   = seq_ff;
            o_first_in = rd_entry.t;
            o_cnt_in   = cnt_ff;
            o_off_in   = '0;
            o_ch_in    = '0;
            o_lvl_in   = '0;
            state_in   = S_HDR;
         end
         S_HDR: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            valid_in   = 1'b1;
            hdr_in     = 1'b0;
            last_in    = (rem_ff == 4'd1);
            o_magic_in = '0;
            o_seq_in   = '0;
            o_first_in = '0;
            o_cnt_in   = '0;
            o_off_in   = (|diff[31:16]) ? OFFSET_MAX : diff[15:0];
            o_ch_in    = rd_entry.ch;
            o_lvl_in   = rd_entry.lvl;
            state_in   = S_REC;
         end
         S_REC: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               pop      = 1'b1;
               rem_in   = rem_ff - 4'd1;
               if (rem_ff == 4'd1) begin
                  seq_in   = seq_ff + 32'd1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // read port catches up with the new head
            state_in = S_CALC;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_build_ff <= '0;
         seq_ff        <= '0;
         valid_ff      <= 1'b0;
         rem_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         last_build_ff <= last_build_in;
         seq_ff        <= seq_in;
         valid_ff      <= valid_in;
         rem_ff        <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      first_ff   <= first_in;
      cnt_ff     <= cnt_in;
      hdr_ff     <= hdr_in;
      last_ff    <= last_in;
      o_magic_ff <= o_magic_in;
      o_seq_ff   <= o_seq_in;
      o_first_ff <= o_first_in;
      o_cnt_ff   <= o_cnt_in;
      o_off_ff   <= o_off_in;
      o_ch_ff    <= o_ch_in;
      o_lvl_ff   <= o_lvl_in;
   end

   assign pop_ctl.push = 1'b0;
   assign pop_ctl.pop  = pop;
   assign idle         = (state_ff == S_IDLE);
   assign rsp_tvalid   = valid_ff;
   assign rsp_tuser    = hdr_ff;
   assign rsp_tlast    = last_ff;
   assign rsp_tdata    = {4'd0, o_lvl_ff, o_ch_ff, o_off_ff, o_cnt_ff,
                          o_first_ff, o_seq_ff, o_magic_ff};

endmodule
`default_nettype wire

[design/eefb_checker.sv]
`default_nettype none
module eefb_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic         rsp_tuser,
   input wire logic         rsp_tlast,
   input wire logic [111:0] rsp_tdata
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // no new input while a frame word is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready during frame output");

   a_hdr_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast && (rsp_tdata[75:72] != 4'd0))
      else $error("bad header word");

   // a header is always followed by a record
   a_hdr_then_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser |=> !rsp_tvalid ##1 rsp_tvalid && !rsp_tuser)
      else $error("header not followed by record");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind edge_event_frame_builder_unit eefb_checker u_eefb_checker (.*);
`default_nettype wire
